// ----- hdl/dst_pkg.sv -----
// Package for the door state tracker: state and operation codes, the
// tracker's state record and the sensor evaluation function.
// No dependencies.
package dst_pkg;

    // Door state codes
    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_OPEN    = 3'd1;
    localparam logic [2:0] ST_CLOSING = 3'd2;
    localparam logic [2:0] ST_CLOSED  = 3'd3;
    localparam logic [2:0] ST_OPENING = 3'd4;

    // Operation codes of an input item
    localparam logic [2:0] OP_ACTIVATE = 3'd0;
    localparam logic [2:0] OP_OPEN     = 3'd1;
    localparam logic [2:0] OP_CLOSE    = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_SENSOR   = 3'd4;

    // Register index on the configuration port
    localparam logic REG_EXPIRY_MS = 1'b0;

    localparam int          TICK_W     = 17;
    localparam logic [16:0] TICK_MAX   = 17'h1FFFF;
    localparam logic [15:0] EXPIRY_RST = 16'd30000;

    typedef struct packed {
        logic [2:0]        door_state;
        logic              top_seen;
        logic              bottom_seen;
        logic              assuming;
        logic [TICK_W-1:0] elapsed;
    } dst_state_t;

    // Evaluate the stored sensor pair against the current door state
    function automatic logic [2:0] derive_state(input logic [2:0] cur,
                                                input logic       top,
                                                input logic       bottom);
        logic [2:0] res;
        res = cur;
        if (!top && !bottom) begin
            res = ST_OPEN;
        end else if (top && bottom) begin
            res = ST_CLOSED;
        end else if (cur == ST_OPEN) begin
            res = ST_CLOSING;
        end else if (cur == ST_CLOSED) begin
            res = ST_OPENING;
        end
        return res;
    endfunction

endpackage

// ----- hdl/dst_core.sv -----
// Next-state logic of the door state tracker for one item.
// Depends on dst_pkg.
module dst_core (
    input  logic [2:0]          op,
    input  logic                top_detect,
    input  logic                bottom_detect,
    input  logic [15:0]         expiry_ms,
    input  dst_pkg::dst_state_t cur,
    output dst_pkg::dst_state_t nxt,
    output logic                changed,
    output logic                pulse
);
    import dst_pkg::*;

    logic [TICK_W-1:0] tick_inc;
    logic [2:0]        derived;
    logic [2:0]        toggle_target;

    // Saturating tick count and sensor evaluation on the stored pair
    assign tick_inc = (cur.elapsed == TICK_MAX) ? cur.elapsed : cur.elapsed + 1'b1;
    assign derived  = derive_state(cur.door_state, cur.top_seen, cur.bottom_seen);
    assign toggle_target = (cur.door_state == ST_OPENING || cur.door_state == ST_OPEN)
                           ? ST_CLOSING : ST_OPENING;

    always_comb
    begin
        logic [2:0] sens;
        nxt     = cur;
        changed = 1'b0;
        pulse   = 1'b0;
        sens    = derive_state(cur.door_state, top_detect, bottom_detect);
        case (op)
            OP_ACTIVATE:
            begin
                pulse = 1'b1;
                if (cur.door_state == ST_UNKNOWN) begin
                    // drop the assumption and evaluate sensors
                    nxt.assuming   = 1'b0;
                    nxt.elapsed    = '0;
                    nxt.door_state = derived;
                    changed        = (derived != cur.door_state);
                end else if (cur.door_state != toggle_target) begin
                    nxt.door_state = toggle_target;
                    nxt.assuming   = 1'b1;
                    nxt.elapsed    = '0;
                    changed        = 1'b1;
                end
            end
            OP_OPEN:
            begin
                if (cur.door_state != ST_OPEN && cur.door_state != ST_OPENING) begin
                    pulse          = 1'b1;
                    nxt.door_state = ST_OPENING;
                    nxt.assuming   = 1'b1;
                    nxt.elapsed    = '0;
                    changed        = 1'b1;
                end
            end
            OP_CLOSE:
            begin
                if (cur.door_state != ST_CLOSED && cur.door_state != ST_CLOSING) begin
                    pulse          = 1'b1;
                    nxt.door_state = ST_CLOSING;
                    nxt.assuming   = 1'b1;
                    nxt.elapsed    = '0;
                    changed        = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (cur.assuming) begin
                    // advance the timer, expire the assumption past the limit
                    if (tick_inc > {1'b0, expiry_ms}) begin
                        nxt.assuming   = 1'b0;
                        nxt.elapsed    = '0;
                        nxt.door_state = derived;
                        changed        = (derived != cur.door_state);
                    end else begin
                        nxt.elapsed = tick_inc;
                    end
                end
            end
            OP_SENSOR:
            begin
                if (top_detect != cur.top_seen || bottom_detect != cur.bottom_seen) begin
                    nxt.top_seen    = top_detect;
                    nxt.bottom_seen = bottom_detect;
                    if (!cur.assuming) begin
                        nxt.door_state = sens;
                        changed        = (sens != cur.door_state);
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- hdl/door_state_tracker.sv -----
// Top level of the door state tracker: input register, state, result
// register and configuration port. Depends on dst_pkg and dst_core.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: op,
//   top_detect, bottom_detect. Output channel (out_valid/out_ready) carries
//   exactly one result per item: door_state, state_changed, remote_pulse.
//   An accepted item is captured in the input register, evaluated against
//   the tracker state and written to the result register once that
//   register is free or being read. One item per cycle is sustained
//   while the receiver takes every result; the state update is a single
//   pass of next-state logic between the input and result registers.
//   When the receiver stalls, the result register holds, the input register
//   fills, and in_ready drops; nothing is lost or repeated.
//   Reset clears the door state to unknown, the sensor pair, the assumption
//   and the timer, and sets expiry_ms to 30000.
//   Configuration: APB write to address 0 sets expiry_ms (low 16 bits).
//   Write only while no item is in flight. pready is tied high.
module door_state_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic        top_detect,
    input  logic        bottom_detect,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  door_state,
    output logic        state_changed,
    output logic        remote_pulse,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dst_pkg::*;

    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic        top_reg;
    logic        bottom_reg;
    logic        out_valid_reg;
    logic [2:0]  state_out_reg;
    logic        changed_reg;
    logic        pulse_reg;
    logic [15:0] expiry_reg;
    dst_state_t  st_reg;
    dst_state_t  st_next;
    logic        changed_next;
    logic        pulse_next;
    logic        advance;
    logic        cfg_write;

    // Move the held item into the result register when it is free
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg     <= op;
            top_reg    <= top_detect;
            bottom_reg <= bottom_detect;
        end
    end

    dst_core u_core (
        .op            (op_reg),
        .top_detect    (top_reg),
        .bottom_detect (bottom_reg),
        .expiry_ms     (expiry_reg),
        .cur           (st_reg),
        .nxt           (st_next),
        .changed       (changed_next),
        .pulse         (pulse_next)
    );

    // Tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '{door_state: ST_UNKNOWN, top_seen: 1'b0, bottom_seen: 1'b0,
                        assuming: 1'b0, elapsed: '0};
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_out_reg <= st_next.door_state;
            changed_reg   <= changed_next;
            pulse_reg     <= pulse_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign door_state    = state_out_reg;
    assign state_changed = changed_reg;
    assign remote_pulse  = pulse_reg;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_EXPIRY_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= EXPIRY_RST;
        end
        else if (cfg_write)
        begin
            expiry_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_EXPIRY_MS) ? {16'd0, expiry_reg} : 32'd0;

    // Timer runs only while a state is assumed
    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.assuming |-> st_reg.elapsed == '0)
        else $error("timer nonzero without assumption");

    // An assumed state is always a moving state
    a_assumed_moving: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.assuming |-> (st_reg.door_state == ST_OPENING ||
                             st_reg.door_state == ST_CLOSING))
        else $error("assumed state is not a moving state");

    // State moves only when an item passes to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("state changed without an item");

    // A fresh result reports the tracker state
    a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (door_state == st_reg.door_state) && out_valid)
        else $error("result state differs from tracker state");

endmodule

// ----- tb/door_state_tracker_test.sv -----
// Testbench for door_state_tracker: commands, ticks and sensor updates are checked
// item by item against a door state predictor, with random idling on both channels.
// Depends on dst_pkg and door_state_tracker.
module door_state_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dst_pkg::*;

    // Op codes the block does not define
    localparam logic [2:0] OP_SPARE_A = 3'd5;
    localparam logic [2:0] OP_SPARE_B = 3'd6;
    localparam logic [2:0] OP_SPARE_C = 3'd7;

    localparam logic [2:0] EXPIRY_ADDR = {REG_EXPIRY_MS, 2'b00};
    localparam int STUCK_LIMIT  = 1000;
    localparam int PHASE_ITEMS  = 415;

    typedef struct packed {
        logic [2:0] state;
        logic       changed;
        logic       pulse;
    } door_result_t;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_BLOCKS} rx_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = OP_ACTIVATE;
    logic        top_detect = 1'b0;
    logic        bottom_detect = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  door_state;
    logic        state_changed;
    logic        remote_pulse;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = EXPIRY_ADDR;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    door_state_tracker dut (.*);

    // Predicted tracker state
    logic [2:0]        door_now = ST_UNKNOWN;
    logic              top_stored = 1'b0;
    logic              bottom_stored = 1'b0;
    logic              holding = 1'b0;
    logic [TICK_W-1:0] held_ticks = '0;
    logic [15:0]       expiry_limit = EXPIRY_RST;

    door_result_t door_expected_q[$];
    int           errors = 0;
    int           stuck_cycles = 0;
    int           sent_items = 0;
    int           burst_left = 0;
    logic         gen_top = 1'b0;
    logic         gen_bottom = 1'b0;

    rx_mode_t rx_mode = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_block_left = 0;
    logic     rx_stalling = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Re-read the stored sensor pair; report whether the door state moved
    function automatic logic reevaluate_sensors();
        logic [2:0] was;
        was = door_now;
        if (!top_stored && !bottom_stored)
        begin
            door_now = ST_OPEN;
        end
        else if (top_stored && bottom_stored)
        begin
            door_now = ST_CLOSED;
        end
        else if (was == ST_OPEN)
        begin
            door_now = ST_CLOSING;
        end
        else if (was == ST_CLOSED)
        begin
            door_now = ST_OPENING;
        end
        return was != door_now;
    endfunction

    function automatic logic release_assumption();
        holding = 1'b0;
        held_ticks = '0;
        return reevaluate_sensors();
    endfunction

    function automatic logic assume_door(logic [2:0] target);
        if (door_now == target)
        begin
            return 1'b0;
        end
        door_now = target;
        holding = 1'b1;
        held_ticks = '0;
        return 1'b1;
    endfunction

    // Advance the predicted tracker by one item and return its result
    function automatic door_result_t predict_door(logic [2:0] o, logic t, logic b);
        door_result_t r;
        logic [2:0]   was;
        was = door_now;
        r.changed = 1'b0;
        r.pulse = 1'b0;
        case (o)
            OP_ACTIVATE:
            begin
                r.pulse = 1'b1;
                if (was == ST_OPENING || was == ST_OPEN)
                begin
                    r.changed = assume_door(ST_CLOSING);
                end
                else if (was == ST_CLOSING || was == ST_CLOSED)
                begin
                    r.changed = assume_door(ST_OPENING);
                end
                else
                begin
                    r.changed = release_assumption();
                end
            end
            OP_OPEN:
            begin
                if (was != ST_OPEN && was != ST_OPENING)
                begin
                    r.pulse = 1'b1;
                    r.changed = assume_door(ST_OPENING);
                end
            end
            OP_CLOSE:
            begin
                if (was != ST_CLOSED && was != ST_CLOSING)
                begin
                    r.pulse = 1'b1;
                    r.changed = assume_door(ST_CLOSING);
                end
            end
            OP_TICK:
            begin
                if (holding)
                begin
                    if (held_ticks < TICK_MAX)
                    begin
                        held_ticks++;
                    end
                    if (held_ticks > {1'b0, expiry_limit})
                    begin
                        r.changed = release_assumption();
                    end
                end
            end
            OP_SENSOR:
            begin
                if (t != top_stored || b != bottom_stored)
                begin
                    top_stored = t;
                    bottom_stored = b;
                    if (!holding)
                    begin
                        r.changed = reevaluate_sensors();
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.state = door_now;
        return r;
    endfunction

    // Check results, predict accepted items, and watch for a hang
    always @(posedge clk)
    begin : result_monitor
        door_result_t got;
        door_result_t want;
        logic         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                got = {door_state, state_changed, remote_pulse};
                if (door_expected_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, %s %0d %0d %0d",
                             $time, "got state, changed, pulse",
                             got.state, got.changed, got.pulse);
                end
                else
                begin
                    want = door_expected_q.pop_front();
                    if (got.state != want.state)
                    begin
                        note_mismatch("door_state", want.state, got.state);
                    end
                    if (got.changed != want.changed)
                    begin
                        note_mismatch("state_changed", want.changed, got.changed);
                    end
                    if (got.pulse != want.pulse)
                    begin
                        note_mismatch("remote_pulse", want.pulse, got.pulse);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                door_expected_q.push_back(predict_door(op, top_detect, bottom_detect));
            end
            if (moved)
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // Drive out_ready: free-running, random, or in stall blocks
    always @(negedge clk)
    begin : result_receiver
        if (rx_mode_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(64, 256);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_FREE:
            begin
                out_ready <= 1'b1;
            end
            RX_RANDOM:
            begin
                out_ready <= ($urandom_range(0, 9) < 7);
            end
            default:
            begin
                if (rx_block_left == 0)
                begin
                    rx_stalling = !rx_stalling;
                    rx_block_left = rx_stalling ? $urandom_range(1, 12) : $urandom_range(1, 16);
                end
                rx_block_left--;
                out_ready <= !rx_stalling;
            end
        endcase
    end

    // Send one item; idle between bursts of random length
    task automatic send_item(input logic [2:0] o, input logic t, input logic b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 20);
        end
        in_valid <= 1'b1;
        op <= o;
        top_detect <= t;
        bottom_detect <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent_items++;
    endtask

    task automatic send_command(input logic [2:0] o);
        send_item(o, 1'($urandom), 1'($urandom));
    endtask

    task automatic send_sensor(input logic t, input logic b);
        gen_top = t;
        gen_bottom = b;
        send_item(OP_SENSOR, t, b);
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_command(OP_TICK);
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (door_expected_q.size() != 0);
    endtask

    task automatic read_back_expiry(input logic [15:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= EXPIRY_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[15:0] != want)
        begin
            note_mismatch("expiry_ms readback", want, prdata[15:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write expiry_ms with junk in the upper bits, then read it back
    task automatic program_expiry(input logic [15:0] value);
        logic [15:0] junk;
        junk = 16'($urandom);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= EXPIRY_ADDR;
        pwdata <= {junk, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        expiry_limit = value;
        @(negedge clk);
        read_back_expiry(value);
    endtask

    task automatic test_register_reset();
        read_back_expiry(EXPIRY_RST);
    endtask

    task automatic test_directed_cases();
        // Ticks while not assuming and undefined ops do nothing
        send_command(OP_TICK);
        send_item(OP_SPARE_A, 1'b1, 1'b1);
        send_item(OP_SPARE_B, 1'b0, 1'b1);
        send_item(OP_SPARE_C, 1'b1, 1'b0);
        // Mixed readings leave an unknown door unknown, then both detectors close it
        send_sensor(1'b1, 1'b0);
        send_command(OP_ACTIVATE);
        send_sensor(1'b0, 1'b1);
        send_sensor(1'b1, 1'b1);
        // Commands against a closed door, assumption blocks sensors
        send_command(OP_CLOSE);
        send_command(OP_ACTIVATE);
        send_command(OP_OPEN);
        send_sensor(1'b0, 1'b0);
        send_command(OP_ACTIVATE);
        send_command(OP_CLOSE);
        send_ticks(2);
        wait_for_results();
        program_expiry(16'd1);
        // Expire the assumption, then work from the stored sensors
        send_ticks(3);
        send_command(OP_OPEN);
        send_sensor(1'b0, 1'b1);
        send_sensor(1'b1, 1'b0);
        send_sensor(1'b1, 1'b0);
        send_command(OP_OPEN);
        send_ticks(2);
        send_sensor(1'b1, 1'b1);
        send_sensor(1'b0, 1'b1);
    endtask

    // One full door travel with an optional command and ticks in between
    task automatic run_door_travel(input int unsigned tick_span);
        logic from_closed;
        logic mid_top;
        from_closed = gen_top & gen_bottom;
        case ($urandom_range(0, 3))
            0: send_command(OP_ACTIVATE);
            1: send_command(OP_OPEN);
            2: send_command(OP_CLOSE);
            default: ;
        endcase
        send_ticks($urandom_range(0, tick_span));
        mid_top = 1'($urandom);
        send_sensor(mid_top, !mid_top);
        if ($urandom_range(0, 4) == 0)
        begin
            send_sensor(mid_top, !mid_top);
        end
        send_ticks($urandom_range(0, tick_span));
        if ($urandom_range(0, 5) == 0)
        begin
            send_sensor(from_closed, from_closed);
        end
        else
        begin
            send_sensor(!from_closed, !from_closed);
        end
    endtask

    task automatic test_random_traffic();
        logic [15:0]  settings[4];
        int           goal;
        int unsigned  lim;
        logic [2:0]   o;
        logic         t;
        logic         b;
        settings = '{16'd1, 16'($urandom_range(2, 6)), 16'($urandom_range(3, 12)), 16'hFFFF};
        foreach (settings[i])
        begin
            wait_for_results();
            program_expiry(settings[i]);
            lim = (settings[i] > 10) ? 10 : settings[i];
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        run_door_travel(lim + 2);
                    end
                    4, 5:
                    begin
                        // Assume a direction, then tick around the expiry point
                        send_command(3'($urandom_range(0, 2)));
                        send_ticks($urandom_range(lim - 1, lim + 2));
                    end
                    6, 7:
                    begin
                        o = 3'($urandom_range(0, 7));
                        t = 1'($urandom);
                        b = 1'($urandom);
                        if (o == OP_SENSOR)
                        begin
                            send_sensor(t, b);
                        end
                        else
                        begin
                            send_item(o, t, b);
                        end
                    end
                    8:
                    begin
                        send_sensor(gen_top, gen_bottom);
                    end
                    default:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            wait_for_results();
                        end
                        send_command(OP_ACTIVATE);
                    end
                endcase
            end
        end
    endtask

    // Largest expiry holds an assumption through a long tick run; a smaller
    // expiry written afterwards drops it on the next tick
    task automatic test_expiry_at_max();
        wait_for_results();
        program_expiry(16'hFFFF);
        send_command(OP_ACTIVATE);
        send_ticks(60);
        send_sensor(!gen_top, gen_bottom);
        send_ticks(2);
        wait_for_results();
        program_expiry(16'($urandom_range(1, 30)));
        send_command(OP_TICK);
        send_command(OP_ACTIVATE);
        send_ticks(3);
    endtask

    initial
    begin : sequencer
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_register_reset();
        test_directed_cases();
        test_random_traffic();
        test_expiry_at_max();
        wait_for_results();
        repeat (8) @(negedge clk);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
